[design/indexed_min_heap_defines.svh]
// Assertion macros for the indexed min-heap checker.
// They sample on clk_i and are disabled while rst_ni is low.
`ifndef INDEXED_MIN_HEAP_DEFINES_SVH
`define INDEXED_MIN_HEAP_DEFINES_SVH

`define IMH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("indexed_min_heap assertion failed");

`define IMH_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("indexed_min_heap assertion failed");

`endif

[design/imh_pkg.sv]
// ----------------------------------------------------------------------------
// imh_pkg
// Types, codes and controller operations shared by the indexed min-heap.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package imh_pkg;

  localparam logic [2:0] CMD_PUSH   = 3'd0;
  localparam logic [2:0] CMD_UPDATE = 3'd1;
  localparam logic [2:0] CMD_POP    = 3'd2;
  localparam logic [2:0] CMD_CLEAR  = 3'd3;
  localparam logic [2:0] CMD_QUERY  = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_EMPTY   = 3'd1;
  localparam logic [2:0] ST_ABSENT  = 3'd2;
  localparam logic [2:0] ST_PRESENT = 3'd3;
  localparam logic [2:0] ST_RANGE   = 3'd4;

  localparam int ID_COUNT = 256;

  localparam logic [4:0] OP_NONE      = 5'd0;
  localparam logic [4:0] OP_PUSH_INIT = 5'd1;
  localparam logic [4:0] OP_POS_RD    = 5'd2;
  localparam logic [4:0] OP_UPD_INIT  = 5'd3;
  localparam logic [4:0] OP_TOP_RD    = 5'd4;
  localparam logic [4:0] OP_POP_TOP   = 5'd5;
  localparam logic [4:0] OP_POP_LAST  = 5'd6;
  localparam logic [4:0] OP_CLEAR     = 5'd7;
  localparam logic [4:0] OP_UP_RD     = 5'd8;
  localparam logic [4:0] OP_UP_MOVE   = 5'd9;
  localparam logic [4:0] OP_DN_RD     = 5'd10;
  localparam logic [4:0] OP_DN_LEFT   = 5'd11;
  localparam logic [4:0] OP_DN_MOVE   = 5'd12;
  localparam logic [4:0] OP_WRITE     = 5'd13;
  localparam logic [4:0] OP_FIN_RD    = 5'd14;
  localparam logic [4:0] OP_FIN_TOP   = 5'd15;
  localparam logic [4:0] OP_FIN_OUT   = 5'd16;

  typedef struct packed {
    logic [2:0]         command;
    logic [7:0]         element_id;
    logic signed [31:0] priority_req;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               heap_empty;
    logic [8:0]         entry_count;
    logic [7:0]         top_element;
    logic signed [31:0] top_priority;
    logic               found;
    logic signed [31:0] found_priority;
  } rsp_t;

  typedef logic [8:0] cfg_t;

  typedef struct packed {
    logic [4:0] op;
    logic       decode;
    logic       latch;
  } ctl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       in_range;
    logic       present;
    logic       empty;
    logic       full;
    logic       single;
    logic       root;
    logic       has_left;
    logic       up_less;
    logic       dn_moves;
    logic       do_down;
    logic       out_free;
  } stat_t;

endpackage

[design/imh_chan_if.sv]
// ----------------------------------------------------------------------------
// imh_chan_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface imh_chan_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[design/imh_ctrl.sv]
// ----------------------------------------------------------------------------
// imh_ctrl
// Command sequencer: decodes a request and steps the datapath through the
// sift loops one memory access at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imh_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  input  imh_pkg::stat_t  st_i,
  output imh_pkg::ctl_t   ctl_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECODE   = 4'd1;
  localparam logic [3:0] S_UPD      = 4'd2;
  localparam logic [3:0] S_POP_TOP  = 4'd3;
  localparam logic [3:0] S_POP_LAST = 4'd4;
  localparam logic [3:0] S_UP       = 4'd5;
  localparam logic [3:0] S_UP_CMP   = 4'd6;
  localparam logic [3:0] S_DN       = 4'd7;
  localparam logic [3:0] S_DN_L     = 4'd8;
  localparam logic [3:0] S_DN_R     = 4'd9;
  localparam logic [3:0] S_WR       = 4'd10;
  localparam logic [3:0] S_FIN      = 4'd11;
  localparam logic [3:0] S_FIN_TOP  = 4'd12;
  localparam logic [3:0] S_FIN_OUT  = 4'd13;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    ctl_o       = '0;
    ctl_o.op    = imh_pkg::OP_NONE;
    req_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          ctl_o.latch = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        ctl_o.decode = 1'b1;
        state_d      = S_FIN;
        case (st_i.cmd)
          imh_pkg::CMD_PUSH: begin
            if (st_i.in_range && !st_i.present && !st_i.full) begin
              ctl_o.op = imh_pkg::OP_PUSH_INIT;
              state_d  = S_UP;
            end
          end
          imh_pkg::CMD_UPDATE: begin
            if (st_i.in_range && st_i.present) begin
              ctl_o.op = imh_pkg::OP_POS_RD;
              state_d  = S_UPD;
            end
          end
          imh_pkg::CMD_POP: begin
            if (!st_i.empty) begin
              ctl_o.op = imh_pkg::OP_TOP_RD;
              state_d  = S_POP_TOP;
            end
          end
          imh_pkg::CMD_CLEAR: begin
            ctl_o.op = imh_pkg::OP_CLEAR;
          end
          default: begin
            ctl_o.op = imh_pkg::OP_NONE;
          end
        endcase
      end
      S_UPD: begin
        ctl_o.op = imh_pkg::OP_UPD_INIT;
        state_d  = S_UP;
      end
      S_POP_TOP: begin
        ctl_o.op = imh_pkg::OP_POP_TOP;
        state_d  = S_POP_LAST;
      end
      S_POP_LAST: begin
        ctl_o.op = imh_pkg::OP_POP_LAST;
        state_d  = st_i.single ? S_FIN : S_DN;
      end
      S_UP: begin
        if (st_i.root) begin
          state_d = st_i.do_down ? S_DN : S_WR;
        end else begin
          ctl_o.op = imh_pkg::OP_UP_RD;
          state_d  = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (st_i.up_less) begin
          ctl_o.op = imh_pkg::OP_UP_MOVE;
          state_d  = S_UP;
        end else begin
          state_d = st_i.do_down ? S_DN : S_WR;
        end
      end
      S_DN: begin
        if (st_i.has_left) begin
          ctl_o.op = imh_pkg::OP_DN_RD;
          state_d  = S_DN_L;
        end else begin
          state_d = S_WR;
        end
      end
      S_DN_L: begin
        ctl_o.op = imh_pkg::OP_DN_LEFT;
        state_d  = S_DN_R;
      end
      S_DN_R: begin
        if (st_i.dn_moves) begin
          ctl_o.op = imh_pkg::OP_DN_MOVE;
          state_d  = S_DN;
        end else begin
          state_d = S_WR;
        end
      end
      S_WR: begin
        ctl_o.op = imh_pkg::OP_WRITE;
        state_d  = S_FIN;
      end
      S_FIN: begin
        ctl_o.op = imh_pkg::OP_FIN_RD;
        state_d  = S_FIN_TOP;
      end
      S_FIN_TOP: begin
        ctl_o.op = imh_pkg::OP_FIN_TOP;
        state_d  = S_FIN_OUT;
      end
      S_FIN_OUT: begin
        if (st_i.out_free) begin
          ctl_o.op = imh_pkg::OP_FIN_OUT;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[design/imh_datapath.sv]
// ----------------------------------------------------------------------------
// imh_datapath
// Entry and position memories, present flags, count, sift registers and the
// result register of the indexed min-heap.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imh_datapath #(
  parameter int ELEMENTS      = 256,
  parameter int PRIORITY_BITS = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  imh_pkg::ctl_t  ctl_i,
  output imh_pkg::stat_t st_o,
  input  imh_pkg::req_t  req_i,
  input  logic           cfg_we_i,
  input  imh_pkg::cfg_t  cfg_data_i,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  output imh_pkg::rsp_t  rsp_o
);

  localparam int PW = (PRIORITY_BITS < 32) ? PRIORITY_BITS : 32;
  localparam int SW = $clog2(ELEMENTS);
  localparam int CW = $clog2(ELEMENTS + 1);
  localparam int NI = imh_pkg::ID_COUNT;

  logic [7:0]           hid_mem [ELEMENTS];
  logic signed [PW-1:0] hpri_mem [ELEMENTS];
  logic [SW-1:0]        pos_mem [NI];

  logic [2:0]           cmd_q;
  logic [7:0]           id_q;
  logic signed [PW-1:0] pri_q;
  logic [2:0]           status_q;
  logic [8:0]           num_q;
  logic [CW-1:0]        count_q;
  logic [NI-1:0]        valid_q;
  logic [SW-1:0]        i_q;
  logic [7:0]           mov_id_q, lft_id_q, top_id_q, rd_id_q;
  logic signed [PW-1:0] mov_pri_q, lft_pri_q, top_pri_q, rd_pri_q;
  logic                 has_r_q, down_q;
  logic [SW-1:0]        pos_rd_q;
  logic                 out_valid_q;
  imh_pkg::rsp_t        out_q;

  logic                 in_range, present, has_l, has_r, sel_l, sel_r;
  logic [SW-1:0]        par;
  logic [CW:0]          l_w, r_w;
  logic signed [PW-1:0] best_pri;
  logic [2:0]           st_code;
  logic                 found;

  logic                 hp_we, hp_re, pos_we, pos_re;
  logic [SW-1:0]        hp_waddr, hp_raddr, pos_wdata;
  logic [7:0]           hp_wid, pos_waddr;
  logic signed [PW-1:0] hp_wpri;

  assign in_range = (32'(id_q) < 32'(num_q)) && (32'(id_q) < ELEMENTS);
  assign present  = valid_q[id_q];
  assign par      = (i_q - SW'(1)) >> 1;
  assign l_w      = (CW+1)'({i_q, 1'b1});
  assign r_w      = l_w + (CW+1)'(1);
  assign has_l    = l_w < (CW+1)'(count_q);
  assign has_r    = r_w < (CW+1)'(count_q);
  assign sel_l    = lft_pri_q < mov_pri_q;
  assign best_pri = sel_l ? lft_pri_q : mov_pri_q;
  assign sel_r    = has_r_q && (rd_pri_q < best_pri);
  assign found    = in_range && present;

  always_comb begin
    case (cmd_q)
      imh_pkg::CMD_PUSH: begin
        st_code = !in_range ? imh_pkg::ST_RANGE :
                  (present ? imh_pkg::ST_PRESENT : imh_pkg::ST_OK);
      end
      imh_pkg::CMD_UPDATE: begin
        st_code = !in_range ? imh_pkg::ST_RANGE :
                  (!present ? imh_pkg::ST_ABSENT : imh_pkg::ST_OK);
      end
      imh_pkg::CMD_POP: begin
        st_code = (count_q == '0) ? imh_pkg::ST_EMPTY : imh_pkg::ST_OK;
      end
      imh_pkg::CMD_QUERY: begin
        st_code = !in_range ? imh_pkg::ST_RANGE : imh_pkg::ST_OK;
      end
      default: begin
        st_code = imh_pkg::ST_OK;
      end
    endcase
  end

  always_comb begin
    st_o          = '0;
    st_o.cmd      = cmd_q;
    st_o.in_range = in_range;
    st_o.present  = present;
    st_o.empty    = count_q == '0;
    st_o.full     = count_q == CW'(ELEMENTS);
    st_o.single   = count_q == CW'(1);
    st_o.root     = i_q == '0;
    st_o.has_left = has_l;
    st_o.up_less  = mov_pri_q < rd_pri_q;
    st_o.dn_moves = sel_l || sel_r;
    st_o.do_down  = down_q;
    st_o.out_free = !out_valid_q || rsp_ready_i;
  end

  always_comb begin
    hp_we     = 1'b0;
    hp_re     = 1'b0;
    pos_we    = 1'b0;
    pos_re    = 1'b0;
    hp_waddr  = i_q;
    hp_raddr  = '0;
    hp_wid    = mov_id_q;
    hp_wpri   = mov_pri_q;
    pos_waddr = mov_id_q;
    pos_wdata = i_q;
    case (ctl_i.op)
      imh_pkg::OP_POS_RD: begin
        pos_re = 1'b1;
      end
      imh_pkg::OP_TOP_RD: begin
        hp_re = 1'b1;
      end
      imh_pkg::OP_POP_TOP: begin
        hp_re    = 1'b1;
        hp_raddr = SW'(count_q - CW'(1));
      end
      imh_pkg::OP_UP_RD: begin
        hp_re    = 1'b1;
        hp_raddr = par;
      end
      imh_pkg::OP_UP_MOVE: begin
        hp_we     = 1'b1;
        hp_wid    = rd_id_q;
        hp_wpri   = rd_pri_q;
        pos_we    = 1'b1;
        pos_waddr = rd_id_q;
      end
      imh_pkg::OP_DN_RD: begin
        hp_re    = 1'b1;
        hp_raddr = SW'(l_w);
      end
      imh_pkg::OP_DN_LEFT: begin
        hp_re    = 1'b1;
        hp_raddr = SW'(r_w);
      end
      imh_pkg::OP_DN_MOVE: begin
        hp_we     = 1'b1;
        hp_wid    = sel_r ? rd_id_q : lft_id_q;
        hp_wpri   = sel_r ? rd_pri_q : lft_pri_q;
        pos_we    = 1'b1;
        pos_waddr = sel_r ? rd_id_q : lft_id_q;
      end
      imh_pkg::OP_WRITE: begin
        hp_we  = 1'b1;
        pos_we = 1'b1;
      end
      imh_pkg::OP_FIN_RD: begin
        hp_re  = 1'b1;
        pos_re = 1'b1;
      end
      imh_pkg::OP_FIN_TOP: begin
        hp_re    = 1'b1;
        hp_raddr = pos_rd_q;
      end
      default: begin
        hp_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (hp_we) begin
      hid_mem[hp_waddr]  <= hp_wid;
      hpri_mem[hp_waddr] <= hp_wpri;
    end
    if (hp_re) begin
      rd_id_q  <= hid_mem[hp_raddr];
      rd_pri_q <= hpri_mem[hp_raddr];
    end
    if (pos_we) begin
      pos_mem[pos_waddr] <= pos_wdata;
    end
    if (pos_re) begin
      pos_rd_q <= pos_mem[id_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q       <= 9'd256;
      count_q     <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        num_q <= cfg_data_i;
      end
      case (ctl_i.op)
        imh_pkg::OP_PUSH_INIT: begin
          count_q       <= count_q + CW'(1);
          valid_q[id_q] <= 1'b1;
        end
        imh_pkg::OP_POP_TOP: begin
          valid_q[rd_id_q] <= 1'b0;
        end
        imh_pkg::OP_POP_LAST: begin
          count_q <= count_q - CW'(1);
        end
        imh_pkg::OP_CLEAR: begin
          count_q <= '0;
          valid_q <= '0;
        end
        default: begin
          count_q <= count_q;
        end
      endcase
      if (ctl_i.op == imh_pkg::OP_FIN_OUT) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) begin
      cmd_q <= req_i.command;
      id_q  <= req_i.element_id;
      pri_q <= PW'(req_i.priority_req);
    end
    if (ctl_i.decode) begin
      status_q <= st_code;
    end
    case (ctl_i.op)
      imh_pkg::OP_PUSH_INIT: begin
        mov_id_q  <= id_q;
        mov_pri_q <= pri_q;
        i_q       <= SW'(count_q);
        down_q    <= 1'b0;
      end
      imh_pkg::OP_UPD_INIT: begin
        mov_id_q  <= id_q;
        mov_pri_q <= pri_q;
        i_q       <= pos_rd_q;
        down_q    <= 1'b1;
      end
      imh_pkg::OP_POP_LAST: begin
        mov_id_q  <= rd_id_q;
        mov_pri_q <= rd_pri_q;
        i_q       <= '0;
      end
      imh_pkg::OP_UP_MOVE: begin
        i_q <= par;
      end
      imh_pkg::OP_DN_LEFT: begin
        lft_id_q  <= rd_id_q;
        lft_pri_q <= rd_pri_q;
        has_r_q   <= has_r;
      end
      imh_pkg::OP_DN_MOVE: begin
        i_q <= sel_r ? SW'(r_w) : SW'(l_w);
      end
      imh_pkg::OP_FIN_TOP: begin
        top_id_q  <= rd_id_q;
        top_pri_q <= rd_pri_q;
      end
      imh_pkg::OP_FIN_OUT: begin
        out_q.status         <= status_q;
        out_q.heap_empty     <= count_q == '0;
        out_q.entry_count    <= 9'(count_q);
        out_q.top_element    <= (count_q != '0) ? top_id_q : 8'd0;
        out_q.top_priority   <= (count_q != '0) ? 32'(top_pri_q) : 32'sd0;
        out_q.found          <= found;
        out_q.found_priority <= found ? 32'(rd_pri_q) : 32'sd0;
      end
      default: begin
        i_q <= i_q;
      end
    endcase
  end

  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = out_q;

endmodule

[design/indexed_min_heap.sv]
// ----------------------------------------------------------------------------
// indexed_min_heap
// Indexed binary min-heap with a position map per element id. A query, a
// clear or a rejected command passes through the decode and finish states
// before the next request can be taken. Every heap step goes through the
// single registered read port of the entry memory, so each level an entry
// rises takes a parent read and a move, and each level it falls takes reads
// of both children and a move. No clearing pass is needed after reset:
// present flags live in flip-flops. The result word is held in an output
// register and the next request is taken while it waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module indexed_min_heap #(
  parameter int ELEMENTS      = 256,
  parameter int PRIORITY_BITS = 32
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  imh_chan_if.sink   req_i,
  imh_chan_if.sink   cfg_i,
  imh_chan_if.source rsp_o
);

  imh_pkg::ctl_t  ctl;
  imh_pkg::stat_t stat;
  logic           req_ready;

  assign req_i.ready = req_ready;
  assign cfg_i.ready = 1'b1;

  imh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .st_i        (stat),
    .ctl_o       (ctl)
  );

  imh_datapath #(
    .ELEMENTS      (ELEMENTS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .st_o        (stat),
    .req_i       (req_i.data),
    .cfg_we_i    (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .rsp_o       (rsp_o.data)
  );

endmodule

[design/imh_checker.sv]
// ----------------------------------------------------------------------------
// imh_checker
// Port-level checks on the result words of the indexed min-heap.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "indexed_min_heap_defines.svh"

module imh_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          rsp_valid_i,
  input logic          rsp_ready_i,
  input imh_pkg::rsp_t rsp_i
);

  `IMH_ASSERT_NXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_i))
  `IMH_ASSERT_IMP(a_empty_count, rsp_valid_i, rsp_i.heap_empty == (rsp_i.entry_count == 9'd0))
  `IMH_ASSERT_IMP(a_empty_top, rsp_valid_i && rsp_i.heap_empty, (rsp_i.top_element == 8'd0) && (rsp_i.top_priority == 32'sd0))
  `IMH_ASSERT_IMP(a_pop_empty, rsp_valid_i && (rsp_i.status == imh_pkg::ST_EMPTY), rsp_i.heap_empty && !rsp_i.found)

endmodule

bind indexed_min_heap imh_checker u_imh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_i       (rsp_o.data)
);
